@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the base64 stream encoder.
// No dependencies; included by the modules that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CHK_CLK(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CHK_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ hw/rtl/b64e_pkg.sv @@
// Package for the base64 stream encoder: group positions, encoder result
// struct and the 6-bit to ASCII alphabet mapping. No dependencies.
package b64e_pkg;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  typedef struct packed {
    logic [5:0] six0;      // first symbol value
    logic [5:0] six1;      // second symbol value
    logic       two;       // second symbol present
    logic       last1;     // second symbol ends the stream
    logic [1:0] pos_nxt;
    logic [3:0] left_nxt;
  } enc_res_t;

  // Alphabet: A-Z, a-z, 0-9, '@', '_'.
  function automatic logic [7:0] ascii_of(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      ascii_of = 8'h41 + w;
    end else if (v < 6'd52) begin
      ascii_of = 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      ascii_of = 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      ascii_of = 8'h40;
    end else begin
      ascii_of = 8'h5f;
    end
  endfunction

endpackage

@@ hw/rtl/b64e_enc.sv @@
// Combinational core of the base64 stream encoder: splits one byte into
// one or two 6-bit groups and computes the next group state. Uses b64e_pkg.
module b64e_enc (
  input  logic [7:0]         data_byte,
  input  logic               final_byte,
  input  logic [1:0]         pos,
  input  logic [3:0]         left,
  output b64e_pkg::enc_res_t res
);
  import b64e_pkg::*;

  always_comb begin
    res = '0;
    unique case (pos)
      POS_SECOND: begin
        res.six0     = {left[1:0], data_byte[7:4]};
        res.six1     = {data_byte[3:0], 2'b00};
        res.two      = final_byte;
        res.pos_nxt  = final_byte ? POS_FIRST : POS_THIRD;
        res.left_nxt = final_byte ? 4'd0 : data_byte[3:0];
      end
      POS_THIRD: begin
        res.six0     = {left, data_byte[7:6]};
        res.six1     = data_byte[5:0];
        res.two      = 1'b1;
        res.pos_nxt  = POS_FIRST;
        res.left_nxt = 4'd0;
      end
      default: begin
        // first byte of a group; the unused code behaves the same
        res.six0     = data_byte[7:2];
        res.six1     = {data_byte[1:0], 4'b0000};
        res.two      = final_byte;
        res.pos_nxt  = final_byte ? POS_FIRST : POS_SECOND;
        res.left_nxt = final_byte ? 4'd0 : {2'b00, data_byte[1:0]};
      end
    endcase
    res.last1 = final_byte;
  end

endmodule

@@ hw/rtl/base64_stream_encoder_top.sv @@
// Top level of the base64 stream encoder: group state, a two-slot symbol
// register and the output register. Uses b64e_pkg, b64e_enc, assert_macros.svh.
//
// Usage:
//   Input channel: in_valid / in_stall with in_data_byte and in_final_byte.
//   One raw byte per item; in_final_byte marks the last byte of a stream.
//   Output channel: out_valid / out_stall with out_symbol (ASCII) and
//   out_last_symbol, high on the final symbol of the stream. No padding.
//   A byte is encoded in the cycle it is accepted into a two-slot symbol
//   register; while out_stall is low, symbols leave one per cycle through
//   the output register, and out_valid rises once a byte's first symbol
//   has moved there. Throughput: one byte per cycle while out_stall is low
//   when it yields one symbol; a byte that yields two keeps the input
//   waiting while both are pending; set by the single symbol output port.
//   A new byte is taken in the same cycle that the last pending symbol moves
//   to the output register, so a last symbol that can move does not block
//   the input. Stall: while out_stall is high a valid output holds, and
//   in_stall holds the input while two symbols are pending or one cannot move.
//   Reset (rst_n low, synchronous): group position and leftover bits clear,
//   all pending symbols are dropped.
`include "assert_macros.svh"

module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_last_symbol
);
  import b64e_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] left_r, left_nxt;
  logic [5:0] slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic       last0_r, last0_nxt, last1_r, last1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] osym_r, osym_nxt;
  logic       olast_r, olast_nxt;
  logic       move, accept;
  enc_res_t   enc;

  b64e_enc u_enc (
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .pos        (pos_r),
    .left       (left_r),
    .res        (enc)
  );

  assign move     = (cnt_r != 2'd0) && (!ovalid_r || !out_stall);
  assign in_stall = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && move));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    slot0_nxt  = slot0_r;
    slot1_nxt  = slot1_r;
    last0_nxt  = last0_r;
    last1_nxt  = last1_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    osym_nxt   = osym_r;
    olast_nxt  = olast_r;

    // advance the output register
    if (move) begin
      ovalid_nxt = 1'b1;
      osym_nxt   = ascii_of(slot0_r);
      olast_nxt  = last0_r;
      slot0_nxt  = slot1_r;
      last0_nxt  = last1_r;
      cnt_nxt    = cnt_r - 2'd1;
    end else if (!out_stall) begin
      ovalid_nxt = 1'b0;
    end

    // load a new item; slots are empty after any move this cycle
    if (accept) begin
      pos_nxt   = enc.pos_nxt;
      left_nxt  = enc.left_nxt;
      slot0_nxt = enc.six0;
      last0_nxt = 1'b0;
      slot1_nxt = enc.six1;
      last1_nxt = enc.last1;
      cnt_nxt   = enc.two ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_FIRST;
      left_r   <= 4'd0;
      cnt_r    <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      left_r   <= left_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    last0_r <= last0_nxt;
    last1_r <= last1_nxt;
    osym_r  <= osym_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_symbol      = osym_r;
  assign out_last_symbol = olast_r;

  `CHK_CLK(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "symbol slot count out of range")
  `CHK_CLK(a_pos_range, clk, rst_n, pos_r != 2'd3, "group position out of range")
  `CHK_CLK(a_final_clears, clk, rst_n, (accept && in_final_byte) |=> (pos_r == POS_FIRST && left_r == 4'd0), "state not cleared after final byte")
  `CHK_CLK(a_two_slots, clk, rst_n, (accept && enc.two) |=> (cnt_r == 2'd2), "two-symbol item not held in both slots")

endmodule
